// ===== rtl/core/i2c_master_register_access_core_assert.svh =====
// Assertion macros for the top module of the I2C master core RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// Shared types, codes and defaults for the I2C master register-access core.
// No dependencies; used by every module of the core.
package i2cm_pkg;

    localparam int WRITE_DEPTH_DEF = 16;

    localparam logic [7:0] TX_PHASE_RST    = 8'd3;
    localparam logic [7:0] RX_PHASE_RST    = 8'd5;
    localparam logic [7:0] START_HOLD_RST  = 8'd10;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] REG_TX_PHASE   = 2'd0;
    localparam logic [1:0] REG_RX_PHASE   = 2'd1;
    localparam logic [1:0] REG_START_HOLD = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ADDR_NACK = 2'd1;
    localparam logic [1:0] STAT_REG_NACK  = 2'd2;
    localparam logic [1:0] STAT_DATA_NACK = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_GAP    = 5'd3,
        PH_TX_SET = 5'd4,
        PH_TX_HI  = 5'd5,
        PH_TX_LO  = 5'd6,
        PH_ACK_LO = 5'd7,
        PH_ACK_HI = 5'd8,
        PH_RX_PRE = 5'd9,
        PH_RX_HI  = 5'd10,
        PH_RX_LO  = 5'd11,
        PH_MA_LO  = 5'd12,
        PH_MA_HI  = 5'd13,
        PH_SP_LO  = 5'd14,
        PH_SP_HI  = 5'd15
    } phase_t;

    typedef enum logic [1:0] {
        STG_ADDR_W = 2'd0,
        STG_REG    = 2'd1,
        STG_ADDR_R = 2'd2,
        STG_DATA   = 2'd3
    } stage_t;

    typedef struct packed {
        logic [7:0] tx_phase;
        logic [7:0] rx_phase;
        logic [7:0] start_hold;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    typedef struct packed {
        logic [1:0] status;
        logic       busy;
        logic       rdata_valid;
        logic [7:0] rdata;
        logic       sda_released;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

// ===== rtl/core/i2c_master_register_access_core.sv =====
// Output: the result of each accepted input transfer is registered and valid in the next cycle.
// Throughput: one item per cycle while the output is taken; the sequencer updates its state
// and the output register in the same cycle, and input stalls (s_tready low) while a result waits.
// Reset: rst_n (async, active low) loads tx/rx/start phase ticks 3/5/10, puts the
// sequencer in idle and empties the write FIFO; FIFO storage itself is not cleared.
module i2c_master_register_access_core #(
    parameter int WRITE_DEPTH = i2cm_pkg::WRITE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // dev_addr[6:0], reg_addr[14:7], length[22:15],
                                   // wdata[30:23], sda_in[31]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], sda_released[2],
                                   // rdata[10:3], rdata_valid[11], busy_res[12],
                                   // status[14:13], zero[15]
    output logic        m_tlast,   // done_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "i2c_master_register_access_core_assert.svh"

    i2cm_pkg::cfg_t       cfg_reg, cfg_next;
    i2cm_pkg::fifo_ctrl_t fifo_ctrl;
    i2cm_pkg::fifo_stat_t fifo_stat;
    i2cm_pkg::result_t    seq_result;
    logic [7:0]           fifo_head;
    logic                 seq_done;
    logic                 accept;
    logic                 cfg_wr;
    logic                 m_tvalid_reg, m_tvalid_next;
    i2cm_pkg::result_t    m_result_reg;
    logic                 m_last_reg;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                i2cm_pkg::REG_TX_PHASE:   cfg_next.tx_phase   = pwdata[7:0];
                i2cm_pkg::REG_RX_PHASE:   cfg_next.rx_phase   = pwdata[7:0];
                i2cm_pkg::REG_START_HOLD: cfg_next.start_hold = pwdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            i2cm_pkg::REG_TX_PHASE:   prdata = {24'd0, cfg_reg.tx_phase};
            i2cm_pkg::REG_RX_PHASE:   prdata = {24'd0, cfg_reg.rx_phase};
            i2cm_pkg::REG_START_HOLD: prdata = {24'd0, cfg_reg.start_hold};
            default:                  prdata = 32'd0;
        endcase
    end

    // Hold a result until taken; load a fresh one on every accepted transfer.
    always_comb
    begin
        if (accept)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_phase   <= i2cm_pkg::TX_PHASE_RST;
            cfg_reg.rx_phase   <= i2cm_pkg::RX_PHASE_RST;
            cfg_reg.start_hold <= i2cm_pkg::START_HOLD_RST;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_result_reg <= seq_result;
            m_last_reg   <= seq_done;
        end
    end

    i2cm_write_fifo #(
        .DEPTH (WRITE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .wdata (s_tdata[30:23]),
        .stat  (fifo_stat),
        .head  (fifo_head)
    );

    i2cm_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (s_tuser),
        .dev_addr  (s_tdata[6:0]),
        .reg_addr  (s_tdata[14:7]),
        .length    (s_tdata[22:15]),
        .sda_in    (s_tdata[31]),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .fifo_head (fifo_head),
        .fifo_ctrl (fifo_ctrl),
        .result    (seq_result),
        .done      (seq_done)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_result_reg.status, m_result_reg.busy,
                       m_result_reg.rdata_valid, m_result_reg.rdata,
                       m_result_reg.sda_released, m_result_reg.sda_level,
                       m_result_reg.scl_level};

    `I2CM_ASSERT_IMPLY(a_rx_while_busy, m_tvalid && m_tdata[11], m_tdata[12],
        "received byte reported outside a transaction")
    `I2CM_ASSERT_IMPLY(a_done_ends_busy, m_tvalid && m_tlast, !m_tdata[12],
        "done reported while still busy")
    `I2CM_ASSERT_IMPLY(a_status_on_done, m_tvalid && (m_tdata[14:13] != 2'd0), m_tlast,
        "error status without done")
    `I2CM_ASSERT_NEXT(a_out_drains, m_tvalid && m_tready && !(s_tvalid && s_tready),
        !m_tvalid, "result repeated after transfer")

endmodule

// ===== rtl/core/i2cm_write_fifo.sv =====
// Write-byte FIFO with a registered head word for the I2C master core.
// Depends on i2cm_pkg for the control and status structs.
module i2cm_write_fifo #(
    parameter int DEPTH = i2cm_pkg::WRITE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cm_pkg::fifo_ctrl_t  ctrl,
    input  logic [7:0]            wdata,
    output i2cm_pkg::fifo_stat_t  stat,
    output logic [7:0]            head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    head_reg;
    logic [SW-1:0] wr_sum;
    logic [AW-1:0] wr_addr;

    // Tail slot is head plus fill count, folded once around the depth.
    assign wr_sum  = SW'(rd_ptr_reg) + SW'(count_reg);
    assign wr_addr = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.clear)
        begin
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            count_next  = count_reg - CW'(1);
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Keep head_reg equal to the entry at the read pointer; bypass a write into it.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_addr] <= wdata;
        end
        if (ctrl.push && (wr_addr == rd_ptr_next))
        begin
            head_reg <= wdata;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head       = head_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

endmodule

// ===== rtl/core/i2cm_sequencer.sv =====
// Bus phase sequencer: advances one time unit per tick transfer and forms the result.
// Depends on i2cm_pkg; drives the write FIFO through fifo_ctrl_t.
module i2cm_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            op,
    input  logic [6:0]            dev_addr,
    input  logic [7:0]            reg_addr,
    input  logic [7:0]            length,
    input  logic                  sda_in,
    input  i2cm_pkg::cfg_t        cfg,
    input  i2cm_pkg::fifo_stat_t  fifo_stat,
    input  logic [7:0]            fifo_head,
    output i2cm_pkg::fifo_ctrl_t  fifo_ctrl,
    output i2cm_pkg::result_t     result,
    output logic                  done
);

    i2cm_pkg::phase_t phase_reg, phase_next;
    i2cm_pkg::stage_t stage_reg, stage_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] left_reg, left_next;
    logic [6:0] taddr_reg, taddr_next;
    logic [7:0] treg_reg, treg_next;
    logic       is_read_reg, is_read_next;
    logic [1:0] err_reg, err_next;

    logic [7:0] tick_inc;
    logic [7:0] plen;
    logic       leave;
    logic [3:0] bit_inc;
    logic [7:0] rx_shift;
    logic [7:0] left_dec;
    logic       rvalid;
    logic [7:0] rbyte;
    logic       scl, sdal, rel;

    function automatic logic [7:0] phase_len(input i2cm_pkg::phase_t ph,
                                              input i2cm_pkg::cfg_t c);
        logic [7:0] len;
        case (ph)
            i2cm_pkg::PH_ST_A, i2cm_pkg::PH_ST_B, i2cm_pkg::PH_GAP: len = c.start_hold;
            i2cm_pkg::PH_RX_PRE, i2cm_pkg::PH_RX_HI, i2cm_pkg::PH_RX_LO,
            i2cm_pkg::PH_MA_LO, i2cm_pkg::PH_MA_HI: len = c.rx_phase;
            default: len = c.tx_phase;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] stage_byte(input i2cm_pkg::stage_t stg,
                                               input logic [6:0] taddr,
                                               input logic [7:0] treg);
        logic [7:0] b;
        case (stg)
            i2cm_pkg::STG_ADDR_W: b = {taddr, 1'b0};
            i2cm_pkg::STG_REG:    b = treg;
            default:              b = {taddr, 1'b1};
        endcase
        return b;
    endfunction

    assign tick_inc = tick_reg + 8'd1;
    assign plen     = phase_len(phase_reg, cfg);
    assign leave    = (tick_inc >= plen);
    assign bit_inc  = bit_reg + 4'd1;
    assign rx_shift = {shift_reg[6:0], sda_in};
    assign left_dec = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        taddr_next   = taddr_reg;
        treg_next    = treg_reg;
        is_read_next = is_read_reg;
        err_next     = err_reg;
        fifo_ctrl    = '0;
        rvalid       = 1'b0;
        rbyte        = 8'd0;
        done         = 1'b0;
        if (accept)
        begin
            case (op)
                i2cm_pkg::OP_LOAD:
                begin
                    if ((phase_reg == i2cm_pkg::PH_IDLE) && !fifo_stat.full)
                    begin
                        fifo_ctrl.push = 1'b1;
                    end
                end
                i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ:
                begin
                    if ((phase_reg == i2cm_pkg::PH_IDLE) &&
                        !((op == i2cm_pkg::OP_READ) && (length == 8'd0)))
                    begin
                        taddr_next   = dev_addr;
                        treg_next    = reg_addr;
                        is_read_next = (op == i2cm_pkg::OP_READ);
                        left_next    = (op == i2cm_pkg::OP_READ) ? length : 8'd0;
                        stage_next   = i2cm_pkg::STG_ADDR_W;
                        err_next     = i2cm_pkg::STAT_OK;
                        tick_next    = 8'd0;
                        phase_next   = i2cm_pkg::PH_ST_A;
                    end
                end
                default:
                begin
                    if (phase_reg != i2cm_pkg::PH_IDLE)
                    begin
                        tick_next = tick_inc;
                        if (leave)
                        begin
                            tick_next = 8'd0;
                            case (phase_reg)
                                i2cm_pkg::PH_ST_A: phase_next = i2cm_pkg::PH_ST_B;
                                i2cm_pkg::PH_ST_B, i2cm_pkg::PH_GAP:
                                begin
                                    if (is_read_reg && (phase_reg == i2cm_pkg::PH_ST_B))
                                    begin
                                        phase_next = i2cm_pkg::PH_GAP;
                                    end
                                    else
                                    begin
                                        shift_next = stage_byte(stage_reg, taddr_reg, treg_reg);
                                        bit_next   = 4'd0;
                                        phase_next = i2cm_pkg::PH_TX_SET;
                                    end
                                end
                                i2cm_pkg::PH_TX_SET: phase_next = i2cm_pkg::PH_TX_HI;
                                i2cm_pkg::PH_TX_HI:  phase_next = i2cm_pkg::PH_TX_LO;
                                i2cm_pkg::PH_TX_LO:
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    bit_next   = bit_inc;
                                    phase_next = (bit_inc >= 4'd8) ? i2cm_pkg::PH_ACK_LO
                                                                   : i2cm_pkg::PH_TX_SET;
                                end
                                i2cm_pkg::PH_ACK_LO: phase_next = i2cm_pkg::PH_ACK_HI;
                                i2cm_pkg::PH_ACK_HI:
                                begin
                                    if (sda_in)
                                    begin
                                        case (stage_reg)
                                            i2cm_pkg::STG_REG:  err_next = i2cm_pkg::STAT_REG_NACK;
                                            i2cm_pkg::STG_DATA: err_next = i2cm_pkg::STAT_DATA_NACK;
                                            default:            err_next = i2cm_pkg::STAT_ADDR_NACK;
                                        endcase
                                        fifo_ctrl.clear = !is_read_reg;
                                        phase_next = i2cm_pkg::PH_SP_LO;
                                    end
                                    else if (stage_reg == i2cm_pkg::STG_ADDR_W)
                                    begin
                                        stage_next = i2cm_pkg::STG_REG;
                                        if (is_read_reg)
                                        begin
                                            phase_next = i2cm_pkg::PH_GAP;
                                        end
                                        else
                                        begin
                                            shift_next = treg_reg;
                                            bit_next   = 4'd0;
                                            phase_next = i2cm_pkg::PH_TX_SET;
                                        end
                                    end
                                    else if ((stage_reg == i2cm_pkg::STG_REG) && is_read_reg)
                                    begin
                                        stage_next = i2cm_pkg::STG_ADDR_R;
                                        phase_next = i2cm_pkg::PH_ST_A;
                                    end
                                    else if (stage_reg == i2cm_pkg::STG_ADDR_R)
                                    begin
                                        bit_next   = 4'd0;
                                        shift_next = 8'd0;
                                        phase_next = i2cm_pkg::PH_RX_PRE;
                                    end
                                    else if (!fifo_stat.empty)
                                    begin
                                        // pop the next write byte and send it
                                        fifo_ctrl.pop = 1'b1;
                                        stage_next    = i2cm_pkg::STG_DATA;
                                        shift_next    = fifo_head;
                                        bit_next      = 4'd0;
                                        phase_next    = i2cm_pkg::PH_TX_SET;
                                    end
                                    else
                                    begin
                                        phase_next = i2cm_pkg::PH_SP_LO;
                                    end
                                end
                                i2cm_pkg::PH_RX_PRE: phase_next = i2cm_pkg::PH_RX_HI;
                                i2cm_pkg::PH_RX_HI:
                                begin
                                    shift_next = rx_shift;
                                    bit_next   = bit_inc;
                                    if (bit_inc >= 4'd8)
                                    begin
                                        rvalid = 1'b1;
                                        rbyte  = rx_shift;
                                    end
                                    phase_next = i2cm_pkg::PH_RX_LO;
                                end
                                i2cm_pkg::PH_RX_LO:
                                    phase_next = (bit_reg >= 4'd8) ? i2cm_pkg::PH_MA_LO
                                                                   : i2cm_pkg::PH_RX_HI;
                                i2cm_pkg::PH_MA_LO: phase_next = i2cm_pkg::PH_MA_HI;
                                i2cm_pkg::PH_MA_HI:
                                begin
                                    left_next  = left_dec;
                                    bit_next   = 4'd0;
                                    shift_next = 8'd0;
                                    phase_next = (left_dec == 8'd0) ? i2cm_pkg::PH_SP_LO
                                                                    : i2cm_pkg::PH_RX_PRE;
                                end
                                i2cm_pkg::PH_SP_LO: phase_next = i2cm_pkg::PH_SP_HI;
                                default:
                                begin
                                    phase_next = i2cm_pkg::PH_IDLE;
                                    done       = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    // Outputs: bus levels follow the phase after this transfer
    always_comb
    begin
        case (phase_next)
            i2cm_pkg::PH_IDLE, i2cm_pkg::PH_ST_A:
            begin
                scl = 1'b1; sdal = 1'b1; rel = 1'b0;
            end
            i2cm_pkg::PH_ST_B, i2cm_pkg::PH_SP_HI:
            begin
                scl = 1'b1; sdal = 1'b0; rel = 1'b0;
            end
            i2cm_pkg::PH_GAP, i2cm_pkg::PH_SP_LO:
            begin
                scl = 1'b0; sdal = 1'b0; rel = 1'b0;
            end
            i2cm_pkg::PH_TX_SET, i2cm_pkg::PH_TX_LO:
            begin
                scl = 1'b0; sdal = shift_next[7]; rel = 1'b0;
            end
            i2cm_pkg::PH_TX_HI:
            begin
                scl = 1'b1; sdal = shift_next[7]; rel = 1'b0;
            end
            i2cm_pkg::PH_ACK_HI, i2cm_pkg::PH_RX_HI:
            begin
                scl = 1'b1; sdal = 1'b1; rel = 1'b1;
            end
            i2cm_pkg::PH_MA_LO:
            begin
                scl = 1'b0; sdal = (left_next <= 8'd1); rel = 1'b0;
            end
            i2cm_pkg::PH_MA_HI:
            begin
                scl = 1'b1; sdal = (left_next <= 8'd1); rel = 1'b0;
            end
            default:
            begin
                scl = 1'b0; sdal = 1'b1; rel = 1'b1;
            end
        endcase
        result.scl_level    = scl;
        result.sda_level    = sdal;
        result.sda_released = rel;
        result.rdata        = rbyte;
        result.rdata_valid  = rvalid;
        result.busy         = (phase_next != i2cm_pkg::PH_IDLE);
        result.status       = done ? err_next : i2cm_pkg::STAT_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cm_pkg::PH_IDLE;
            stage_reg   <= i2cm_pkg::STG_ADDR_W;
            tick_reg    <= 8'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            left_reg    <= 8'd0;
            taddr_reg   <= 7'd0;
            treg_reg    <= 8'd0;
            is_read_reg <= 1'b0;
            err_reg     <= i2cm_pkg::STAT_OK;
        end
        else
        begin
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            taddr_reg   <= taddr_next;
            treg_reg    <= treg_next;
            is_read_reg <= is_read_next;
            err_reg     <= err_next;
        end
    end

endmodule
